@@ hw/rtl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`endif

@@ hw/rtl/avtm_pkg.sv @@
package avtm_pkg;
  localparam int unsigned PtrBits = 8;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned StampBits = 31;
  localparam logic [63:0] NsPerMs = 64'd1000000;

  typedef enum logic [1:0] {
    FUNC_AUDIO = 2'd0,
    FUNC_VIDEO = 2'd1,
    FUNC_TAKE  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOT_RUN  = 3'd2,
    ST_EMITTED  = 3'd3,
    ST_NOTHING  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_RUNNING = 2'd0,
    REG_START   = 2'd1,
    REG_NUMER   = 2'd2,
    REG_DENOM   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MUL2,
    S_DIV,
    S_WRITE,
    S_READ,
    S_PICK
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;
endpackage

@@ hw/rtl/av_timestamp_merge_queues_unit.sv @@
// Two timestamp ring queues (audio, video) with an ordered merge on take.
// A submit that converts a nonzero time runs the 64x32 multiply on one 32x32
// multiplier, low half of the time then high half, then one 64-step pass of
// the shared restoring divider by the timebase denominator times one million,
// then a queue write, after which done_o shows the result. A take that emits
// reads both heads and pops the smaller stamp, video on a tie; a submit with
// no timestamp goes straight to the write. A dropped submit or a take with a
// queue empty finishes at once. busy stays high until done_o; each result is
// shown for one cycle with done_o high and cannot be stalled by the receiver.
`include "assert_macros.svh"
module av_timestamp_merge_queues_unit #(
  parameter int unsigned PtrBits = avtm_pkg::PtrBits,
  parameter int unsigned HandleBits = avtm_pkg::HandleBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [63:0]           cfg_wdata_i,
  input  logic [1:0]            func_i,
  input  logic [HandleBits-1:0] packet_handle_i,
  input  logic signed [63:0]    raw_time_i,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic [HandleBits-1:0] out_handle_o,
  output logic [30:0]           out_timestamp_o,
  output logic                  out_is_video_o,
  output logic                  out_header_large_o
);
  localparam int unsigned W = HandleBits + avtm_pkg::StampBits + 1;

  logic        running_q;
  logic [62:0] start_time_q;
  logic [31:0] numer_q, denom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      start_time_q <= '0;
      numer_q <= 32'd1;
      denom_q <= 32'd1;
    end else if (cfg_we_i) begin
      case (avtm_pkg::reg_e'(cfg_idx_i))
        avtm_pkg::REG_RUNNING: running_q <= cfg_wdata_i[0];
        avtm_pkg::REG_START:   start_time_q <= cfg_wdata_i[62:0];
        avtm_pkg::REG_NUMER:   numer_q <= cfg_wdata_i[31:0];
        avtm_pkg::REG_DENOM:   denom_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  avtm_pkg::state_e state_q, state_d;
  logic             vid_q;
  logic [HandleBits-1:0] hdl_q;
  logic [63:0]      t_q, t_d;
  logic [63:0]      prod_q, prod_d;
  logic [2:0]       st_d;
  logic             fin;
  logic             emit_vid;

  avtm_pkg::div_req_t div_req;
  avtm_pkg::div_rsp_t div_rsp;
  logic push_a, push_v, pop_a, pop_v, rd;
  logic [W-1:0] wdata, rd_a, rd_v;
  logic emp_a, emp_v, full_a, full_v;

  avtm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  avtm_queue #(.PtrBits(PtrBits), .HandleBits(HandleBits)) u_qa (
    .clk_i, .rst_ni, .push_i(push_a), .wdata_i(wdata), .pop_i(pop_a), .rd_i(rd),
    .rdata_o(rd_a), .empty_o(emp_a), .full_o(full_a));
  avtm_queue #(.PtrBits(PtrBits), .HandleBits(HandleBits)) u_qv (
    .clk_i, .rst_ni, .push_i(push_v), .wdata_i(wdata), .pop_i(pop_v), .rd_i(rd),
    .rdata_o(rd_v), .empty_o(emp_v), .full_o(full_v));

  logic accept;
  logic [63:0] diff;
  logic [30:0] a_stamp, v_stamp;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [31:0] denom_eff;
  assign accept = start && !busy;
  assign diff = raw_time_i - {1'b0, start_time_q};
  assign a_stamp = rd_a[avtm_pkg::StampBits:1];
  assign v_stamp = rd_v[avtm_pkg::StampBits:1];
  assign emit_vid = !(a_stamp < v_stamp);

  // one 32x32 multiplier, low half of t then high half
  assign mul_a = (state_q == avtm_pkg::S_MUL2) ? t_q[63:32] : t_q[31:0];
  assign mul_p = 64'(mul_a) * 64'(numer_q);
  assign denom_eff = (denom_q == '0) ? 32'd1 : denom_q;

  // next state
  always_comb begin
    state_d = state_q;
    st_d = avtm_pkg::ST_QUEUED;
    fin = 1'b0;
    case (state_q)
      avtm_pkg::S_IDLE: begin
        if (accept) begin
          if (func_i == avtm_pkg::FUNC_AUDIO || func_i == avtm_pkg::FUNC_VIDEO) begin
            if (!running_q) begin
              fin = 1'b1;
              st_d = avtm_pkg::ST_NOT_RUN;
            end else if ((func_i == avtm_pkg::FUNC_AUDIO) ? full_a : full_v) begin
              fin = 1'b1;
              st_d = avtm_pkg::ST_FULL;
            end else if (raw_time_i == '0) begin
              state_d = avtm_pkg::S_WRITE;
            end else begin
              state_d = avtm_pkg::S_MUL;
            end
          end else if (func_i == avtm_pkg::FUNC_TAKE && !emp_a && !emp_v) begin
            state_d = avtm_pkg::S_READ;
          end else begin
            fin = 1'b1;
            st_d = avtm_pkg::ST_NOTHING;
          end
        end
      end
      avtm_pkg::S_MUL:  state_d = avtm_pkg::S_MUL2;
      avtm_pkg::S_MUL2: state_d = avtm_pkg::S_DIV;
      avtm_pkg::S_DIV:  if (div_rsp.done) state_d = avtm_pkg::S_WRITE;
      avtm_pkg::S_WRITE: begin
        state_d = avtm_pkg::S_IDLE;
        fin = 1'b1;
      end
      avtm_pkg::S_READ: state_d = avtm_pkg::S_PICK;
      avtm_pkg::S_PICK: begin
        state_d = avtm_pkg::S_IDLE;
        fin = 1'b1;
        st_d = avtm_pkg::ST_EMITTED;
      end
      default: state_d = avtm_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    t_d = t_q;
    prod_d = prod_q;
    div_req = '0;
    push_a = 1'b0;
    push_v = 1'b0;
    pop_a = 1'b0;
    pop_v = 1'b0;
    rd = 1'b0;
    case (state_q)
      avtm_pkg::S_IDLE: begin
        if (accept) begin
          t_d = (raw_time_i == '0) ? 64'd0 : diff;
        end
      end
      avtm_pkg::S_MUL: prod_d = mul_p;
      avtm_pkg::S_MUL2: begin
        // truncating twice equals one divide by the product of both divisors
        div_req.start = 1'b1;
        div_req.dividend = prod_q + {mul_p[31:0], 32'd0};
        div_req.divisor = 64'(denom_eff) * avtm_pkg::NsPerMs;
      end
      avtm_pkg::S_DIV: begin
        if (div_rsp.done) begin
          t_d = div_rsp.quot[63] ? 64'd0 : div_rsp.quot;
        end
      end
      avtm_pkg::S_WRITE: begin
        push_a = !vid_q;
        push_v = vid_q;
      end
      avtm_pkg::S_READ: rd = 1'b1;
      avtm_pkg::S_PICK: begin
        pop_a = !emit_vid;
        pop_v = emit_vid;
      end
      default: ;
    endcase
  end

  assign wdata = {hdl_q, t_q[30:0], (t_q == '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= avtm_pkg::S_IDLE;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    prod_q <= prod_d;
    if (accept) begin
      vid_q <= (func_i == avtm_pkg::FUNC_VIDEO);
      hdl_q <= packet_handle_i;
    end
    if (fin) begin
      status_o <= st_d;
      if (st_d == avtm_pkg::ST_EMITTED) begin
        out_handle_o <= emit_vid ? rd_v[W-1 -: HandleBits] : rd_a[W-1 -: HandleBits];
        out_timestamp_o <= emit_vid ? v_stamp : a_stamp;
        out_is_video_o <= emit_vid;
        out_header_large_o <= emit_vid ? rd_v[0] : rd_a[0];
      end else begin
        out_handle_o <= '0;
        out_timestamp_o <= '0;
        out_is_video_o <= 1'b0;
        out_header_large_o <= 1'b0;
      end
    end
  end

  assign busy = (state_q != avtm_pkg::S_IDLE);

  `ASSERT_NEVER(a_push_both, clk_i, rst_ni, push_a && push_v, "both queues pushed")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, (pop_a && emp_a) || (pop_v && emp_v), "pop empty")
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o |-> !busy, "done while busy")
endmodule

@@ hw/rtl/avtm_div.sv @@
module avtm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avtm_pkg::div_req_t  req_i,
  output avtm_pkg::div_rsp_t  rsp_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    busy_d = busy_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    shifted = {rem_q[62:0], quo_q[63]};
    trial = {1'b0, shifted} - {1'b0, dvs_q};
    if (req_i.start) begin
      neg_d = req_i.dividend[63];
      quo_d = req_i.dividend[63] ? (64'd0 - req_i.dividend) : req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
      end else begin
        rem_d = shifted;
      end
      quo_d = {quo_q[62:0], ~trial[64]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (64'd0 - quo_q) : quo_q;
endmodule

@@ hw/rtl/avtm_queue.sv @@
module avtm_queue #(
  parameter int unsigned PtrBits = avtm_pkg::PtrBits,
  parameter int unsigned HandleBits = avtm_pkg::HandleBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic [HandleBits+avtm_pkg::StampBits:0] wdata_i,
  input  logic                                  pop_i,
  input  logic                                  rd_i,
  output logic [HandleBits+avtm_pkg::StampBits:0] rdata_o,
  output logic                                  empty_o,
  output logic                                  full_o
);
  localparam int unsigned W = HandleBits + avtm_pkg::StampBits + 1;
  logic [W-1:0] mem [2**PtrBits];
  logic [PtrBits-1:0] rp_q, wp_q, cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= wdata_i;
    end
    if (rd_i) begin
      rdata_o <= mem[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      wp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == '1);
endmodule
